// File: rtl/core/odo_pkg.sv
// Shared types, constants and the arctangent table for the odometry core.
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

   localparam int ACC_W     = 48;   // state and result width, Q15.32
   localparam int WIDE_W    = 64;   // width of intermediate distances
   localparam int MB_W      = 40;   // multiplier operand B width
   localparam int PROD_W    = WIDE_W + MB_W;
   localparam int MUL_STEPS = MB_W;
   localparam int STEP_W    = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // heading reduction: quotient estimate, subtract, one correction
   localparam int RED_STEPS  = 3;
   localparam int RED_SHIFT  = 22;   // low heading bits left out of the estimate
   localparam int RED_FRAC   = 32;   // fraction bits of the reciprocal
   localparam int RED_R_W    = 20;
   localparam int RED_Q_W    = 14;
   localparam int RED_PROD_W = ACC_W - RED_SHIFT + RED_R_W;
   localparam logic [STEP_W-1:0] RED_EST = STEP_W'(0);
   localparam logic [STEP_W-1:0] RED_SUB = STEP_W'(1);

   localparam logic signed [ACC_W-1:0] TWO_PI_Q32  = 48'sd26986075409;
   localparam logic signed [ACC_W-1:0] PI_Q32      = 48'sd13493037705;
   localparam logic signed [ACC_W-1:0] HALF_PI_Q32 = 48'sd6746518852;
   localparam logic signed [ACC_W-1:0] GAIN_Q32    = 48'sd2608131496;

   // floor(2^54 / 2pi_q32), never above the true reciprocal
   localparam logic [RED_R_W-1:0] RED_RECIP =
      RED_R_W'((64'd1 << (RED_SHIFT + RED_FRAC)) / 64'(TWO_PI_Q32));

   localparam logic [31:0] ATAN_LOW [0:10] = '{
      32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
      32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
      32'd16777131, 32'd8388597, 32'd4194303};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ENCODER_RANGE  = 3'd0,
      REG_WRAP_THRESHOLD = 3'd1,
      REG_DIST_PER_COUNT = 3'd2,
      REG_INV_WHEEL_BASE = 3'd3,
      REG_ANGLE_PER_COUNT = 3'd4
   } reg_idx_type;

   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_LOAD     = 4'd1,
      OP_MUL_GO   = 4'd2,
      OP_MUL_STORE = 4'd3,
      OP_RED_INIT = 4'd4,
      OP_RED      = 4'd5,
      OP_FOLD     = 4'd6,
      OP_ROT      = 4'd7,
      OP_EMIT     = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      JOB_LDIST = 3'd0,
      JOB_RDIST = 3'd1,
      JOB_LANG  = 3'd2,
      JOB_RANG  = 3'd3,
      JOB_DTH   = 3'd4,
      JOB_PX    = 3'd5,
      JOB_PY    = 3'd6
   } job_type;

   typedef struct packed {
      op_type              op;
      job_type             job;
      logic [STEP_W-1:0]   step;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic out_full;
   } stat_type;

   // atan(2^-i) in Q32
   function automatic logic [ACC_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      logic [ACC_W-1:0] r;
      r = '0;
      if (i < 6'd11) begin
         r = ACC_W'(ATAN_LOW[i[3:0]]);
      end else if (i <= 6'd32) begin
         r = ACC_W'(1) << (6'd32 - i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/odo_mul.sv
// Bit-serial shift-add multiplier, 64 x 40 bits, one bit of B per cycle.
`timescale 1ns / 1ps
`default_nettype none
module odo_mul (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [odo_pkg::WIDE_W-1:0] a,
   input  wire logic [odo_pkg::MB_W-1:0]          b,
   input  wire logic                              b_signed,
   output logic                                   done,
   output logic [odo_pkg::PROD_W-1:0]             prod
);

   logic [odo_pkg::PROD_W-1:0] mcand_ff, mcand_in, acc_ff, acc_in;
   logic [odo_pkg::MB_W-1:0]   mplier_ff, mplier_in;
   logic [odo_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in, sgn_ff, sgn_in;
   logic last;

   assign last = (cnt_ff == odo_pkg::STEP_W'(odo_pkg::MUL_STEPS - 1));

   always_comb begin
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      sgn_in    = sgn_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = odo_pkg::PROD_W'(a);
         mplier_in = b;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
         sgn_in    = b_signed;
      end else if (busy_ff) begin
         // top bit of a signed B carries negative weight
         if (mplier_ff[0]) begin
            if (last && sgn_ff) begin
               acc_in = acc_ff - mcand_ff;
            end else begin
               acc_in = acc_ff + mcand_ff;
            end
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      sgn_ff    <= sgn_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule
`default_nettype wire

// File: rtl/core/odo_datapath.sv
// Odometry datapath: registers, wrap correction, reduction, CORDIC and result register.
`timescale 1ns / 1ps
`default_nettype none
module odo_datapath #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire odo_pkg::cmd_type                    cmd,
   output odo_pkg::stat_type                        stat,
   input  wire logic [COUNT_WIDTH-1:0]              cnt_left,
   input  wire logic [COUNT_WIDTH-1:0]              cnt_right,
   input  wire logic                                mode,
   input  wire logic                                csr_we,
   input  wire logic [odo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [odo_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [5*odo_pkg::ACC_W-1:0]              rsp_tdata
);

   localparam int DW = ((COUNT_WIDTH > 17) ? COUNT_WIDTH : 17) + 2;
   localparam int AW = odo_pkg::ACC_W;
   localparam int WW = odo_pkg::WIDE_W;

   // configuration
   logic [16:0] range_ff;
   logic [15:0] thr_ff;
   logic [31:0] dpc_ff, apc_ff;
   logic [23:0] ibw_ff;

   // architectural state
   logic [COUNT_WIDTH-1:0] last_l_ff, last_r_ff;
   logic signed [AW-1:0] px_ff, py_ff, head_ff, lt_ff, rt_ff;

   // working registers
   logic signed [DW-1:0] dl_ff, dr_ff;
   logic signed [WW-1:0] ldist_ff, rdist_ff;
   logic [AW-1:0]        rem_ff;
   logic [odo_pkg::RED_Q_W-1:0] quo_ff;
   logic                 hneg_ff, neg_ff;
   logic signed [AW-1:0] x_ff, y_ff, z_ff;
   logic                 ovalid_ff;
   logic [5*AW-1:0]      odata_ff;

   logic signed [DW-1:0] dl_in, dr_in;

   function automatic logic signed [DW-1:0] wrap_delta(
      input logic [COUNT_WIDTH-1:0] now, input logic [COUNT_WIDTH-1:0] prev,
      input logic [15:0] thr, input logic [16:0] rng);
      logic signed [DW-1:0] d, t, r;
      d = DW'(now) - DW'(prev);
      t = DW'(thr);
      r = DW'(rng);
      if (d > t) begin
         d = d - r;
      end else if (d < -t) begin
         d = d + r;
      end
      return d;
   endfunction

   assign dl_in = wrap_delta(cnt_left, last_l_ff, thr_ff, range_ff);
   assign dr_in = wrap_delta(cnt_right, last_r_ff, thr_ff, range_ff);

   // multiplier operands
   logic signed [WW-1:0] mul_a, mean, diff;
   logic [odo_pkg::MB_W-1:0] mul_b;
   logic mul_bs, mul_done;
   logic [odo_pkg::PROD_W-1:0] prod;
   logic signed [AW-1:0] cos_v, sin_v;

   assign mean  = (ldist_ff + rdist_ff) >>> 1;
   assign diff  = rdist_ff - ldist_ff;
   assign cos_v = neg_ff ? -x_ff : x_ff;
   assign sin_v = neg_ff ? -y_ff : y_ff;

   always_comb begin
      mul_a  = WW'(dl_ff);
      mul_b  = odo_pkg::MB_W'(dpc_ff);
      mul_bs = 1'b0;
      case (cmd.job)
         odo_pkg::JOB_LDIST: begin
            mul_a = WW'(dl_ff);
            mul_b = odo_pkg::MB_W'(dpc_ff);
         end
         odo_pkg::JOB_RDIST: begin
            mul_a = WW'(dr_ff);
            mul_b = odo_pkg::MB_W'(dpc_ff);
         end
         odo_pkg::JOB_LANG: begin
            mul_a = WW'(dl_ff);
            mul_b = odo_pkg::MB_W'(apc_ff);
         end
         odo_pkg::JOB_RANG: begin
            mul_a = WW'(dr_ff);
            mul_b = odo_pkg::MB_W'(apc_ff);
         end
         odo_pkg::JOB_DTH: begin
            mul_a = diff;
            mul_b = odo_pkg::MB_W'(ibw_ff);
         end
         odo_pkg::JOB_PX: begin
            mul_a  = mean;
            mul_b  = cos_v[odo_pkg::MB_W-1:0];
            mul_bs = 1'b1;
         end
         odo_pkg::JOB_PY: begin
            mul_a  = mean;
            mul_b  = sin_v[odo_pkg::MB_W-1:0];
            mul_bs = 1'b1;
         end
         default: begin
            mul_a  = WW'(dl_ff);
            mul_bs = 1'b0;
         end
      endcase
   end

   odo_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == odo_pkg::OP_MUL_GO),
      .a        (mul_a),
      .b        (mul_b),
      .b_signed (mul_bs),
      .done     (mul_done),
      .prod     (prod)
   );

   // |heading| mod 2pi: the quotient estimate is at most one short
   logic [odo_pkg::RED_PROD_W-1:0] red_prod;
   logic [AW-1:0]                  red_sub, two_pi;
   assign two_pi   = $unsigned(odo_pkg::TWO_PI_Q32);
   assign red_prod = odo_pkg::RED_PROD_W'(rem_ff[AW-1:odo_pkg::RED_SHIFT])
                     * odo_pkg::RED_PROD_W'(odo_pkg::RED_RECIP);
   assign red_sub  = AW'(quo_ff) * two_pi;

   // range folding into [-pi/2, pi/2]
   logic signed [AW-1:0] r0, r1, zf;
   logic nf;
   always_comb begin
      r0 = hneg_ff ? -$signed(rem_ff) : $signed(rem_ff);
      r1 = r0;
      if (r0 > odo_pkg::PI_Q32) begin
         r1 = r0 - odo_pkg::TWO_PI_Q32;
      end else if (r0 < -odo_pkg::PI_Q32) begin
         r1 = r0 + odo_pkg::TWO_PI_Q32;
      end
      zf = r1;
      nf = 1'b0;
      if (r1 > odo_pkg::HALF_PI_Q32) begin
         zf = r1 - odo_pkg::PI_Q32;
         nf = 1'b1;
      end else if (r1 < -odo_pkg::HALF_PI_Q32) begin
         zf = r1 + odo_pkg::PI_Q32;
         nf = 1'b1;
      end
   end

   // one CORDIC micro-rotation
   logic signed [AW-1:0] xs, ys, at;
   assign xs = x_ff >>> cmd.step;
   assign ys = y_ff >>> cmd.step;
   assign at = $signed(odo_pkg::atan_step(cmd.step));

   logic out_full;
   assign out_full      = ovalid_ff && !rsp_tready;
   assign stat.mul_done = mul_done;
   assign stat.out_full = out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff  <= 17'd65536;
         thr_ff    <= 16'd32767;
         dpc_ff    <= '0;
         ibw_ff    <= '0;
         apc_ff    <= '0;
         last_l_ff <= '0;
         last_r_ff <= '0;
         px_ff     <= '0;
         py_ff     <= '0;
         head_ff   <= '0;
         lt_ff     <= '0;
         rt_ff     <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               odo_pkg::REG_ENCODER_RANGE:   range_ff <= csr_wdata[16:0];
               odo_pkg::REG_WRAP_THRESHOLD:  thr_ff   <= csr_wdata[15:0];
               odo_pkg::REG_DIST_PER_COUNT:  dpc_ff   <= csr_wdata;
               odo_pkg::REG_INV_WHEEL_BASE:  ibw_ff   <= csr_wdata[23:0];
               odo_pkg::REG_ANGLE_PER_COUNT: apc_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (ovalid_ff && rsp_tready) begin
            ovalid_ff <= 1'b0;
         end
         case (cmd.op)
            odo_pkg::OP_LOAD: begin
               last_l_ff <= cnt_left;
               last_r_ff <= cnt_right;
               if (mode) begin
                  px_ff   <= '0;
                  py_ff   <= '0;
                  head_ff <= '0;
                  lt_ff   <= '0;
                  rt_ff   <= '0;
               end
            end
            odo_pkg::OP_MUL_STORE: begin
               case (cmd.job)
                  odo_pkg::JOB_LANG: lt_ff   <= lt_ff + $signed(prod[55:8]);
                  odo_pkg::JOB_RANG: rt_ff   <= rt_ff + $signed(prod[55:8]);
                  odo_pkg::JOB_DTH:  head_ff <= head_ff + $signed(prod[71:24]);
                  odo_pkg::JOB_PX:   px_ff   <= px_ff + $signed(prod[87:40]);
                  odo_pkg::JOB_PY:   py_ff   <= py_ff + $signed(prod[87:40]);
                  default: ;
               endcase
            end
            odo_pkg::OP_EMIT: begin
               ovalid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         odo_pkg::OP_LOAD: begin
            dl_ff <= dl_in;
            dr_ff <= dr_in;
         end
         odo_pkg::OP_MUL_STORE: begin
            if (cmd.job == odo_pkg::JOB_LDIST) begin
               ldist_ff <= $signed(prod[WW-1:0]);
            end
            if (cmd.job == odo_pkg::JOB_RDIST) begin
               rdist_ff <= $signed(prod[WW-1:0]);
            end
         end
         odo_pkg::OP_RED_INIT: begin
            hneg_ff <= head_ff[AW-1];
            rem_ff  <= head_ff[AW-1] ? -head_ff : head_ff;
         end
         odo_pkg::OP_RED: begin
            if (cmd.step == odo_pkg::RED_EST) begin
               quo_ff <= red_prod[odo_pkg::RED_PROD_W-1:odo_pkg::RED_FRAC];
            end else if (cmd.step == odo_pkg::RED_SUB) begin
               rem_ff <= rem_ff - red_sub;
            end else if (rem_ff >= two_pi) begin
               rem_ff <= rem_ff - two_pi;
            end
         end
         odo_pkg::OP_FOLD: begin
            z_ff   <= zf;
            neg_ff <= nf;
            x_ff   <= odo_pkg::GAIN_Q32;
            y_ff   <= '0;
         end
         odo_pkg::OP_ROT: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
         end
         odo_pkg::OP_EMIT: begin
            odata_ff <= {rt_ff, lt_ff, head_ff, py_ff, px_ff};
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

endmodule
`default_nettype wire

// File: rtl/core/odo_ctrl.sv
// Odometry sequencer: steps the datapath through deltas, products, reduction and CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module odo_ctrl #(
   parameter int CORDIC_STEPS = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               mode,
   input  wire odo_pkg::stat_type  stat,
   output odo_pkg::cmd_type        cmd
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MGO   = 8'b0000_0010,
      S_MWAIT = 8'b0000_0100,
      S_RINIT = 8'b0000_1000,
      S_RED   = 8'b0001_0000,
      S_FOLD  = 8'b0010_0000,
      S_ROT   = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type                  state_ff, state_in;
   odo_pkg::job_type           job_ff, job_in;
   logic [odo_pkg::STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd.op     = odo_pkg::OP_NONE;
      cmd.job    = job_ff;
      cmd.step   = step_ff;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = odo_pkg::OP_LOAD;
               job_in = odo_pkg::JOB_LDIST;
               state_in = mode ? S_EMIT : S_MGO;
            end
         end
         S_MGO: begin
            cmd.op   = odo_pkg::OP_MUL_GO;
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            if (stat.mul_done) begin
               cmd.op = odo_pkg::OP_MUL_STORE;
               if (job_ff == odo_pkg::JOB_DTH) begin
                  state_in = S_RINIT;
               end else if (job_ff == odo_pkg::JOB_PY) begin
                  state_in = S_EMIT;
               end else begin
                  job_in   = odo_pkg::job_type'(job_ff + 3'd1);
                  state_in = S_MGO;
               end
            end
         end
         S_RINIT: begin
            cmd.op   = odo_pkg::OP_RED_INIT;
            step_in  = '0;
            state_in = S_RED;
         end
         S_RED: begin
            cmd.op  = odo_pkg::OP_RED;
            step_in = step_ff + 1'b1;
            if (step_ff == odo_pkg::STEP_W'(odo_pkg::RED_STEPS - 1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            cmd.op   = odo_pkg::OP_FOLD;
            step_in  = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            cmd.op  = odo_pkg::OP_ROT;
            step_in = step_ff + 1'b1;
            if (step_ff == odo_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
               job_in   = odo_pkg::JOB_PX;
               state_in = S_MGO;
            end
         end
         S_EMIT: begin
            if (!stat.out_full) begin
               cmd.op   = odo_pkg::OP_EMIT;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         job_ff   <= odo_pkg::JOB_LDIST;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         step_ff  <= step_in;
      end
   end

   // a product is only stored while one is awaited
   assert property (@(posedge clock) disable iff (reset)
      stat.mul_done |-> state_ff == S_MWAIT)
      else $error("multiplier finished outside wait state");

   // the multiplier never starts with the result register still owed
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MGO) |=> (state_ff == S_MWAIT) && !stat.mul_done)
      else $error("multiplier start sequencing broken");

   // after the fold, rotation starts at step zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD) |=> (state_ff == S_ROT) && (step_ff == '0))
      else $error("CORDIC did not start at step zero");

endmodule
`default_nettype wire

// File: rtl/core/diff_drive_encoder_odometry_core.sv
// Differential-drive wheel odometry core: top level.
//
// Input stream req_*: one transfer carries mode and the two raw encoder counts.
// Mode 0 updates odometry from the count deltas, mode 1 latches the counts and
// zeroes pose, heading and motor angles. Every input transfer yields exactly one
// result transfer on rsp_* holding x, y, heading and both motor angles (Q15.32).
// Items are processed one at a time. An update runs seven products on the
// bit-serial 64 x 40 multiplier, a 3-step modulo-2pi reduction, CORDIC_STEPS
// rotation steps and the accept, setup and emit steps; an init item goes from
// accept straight to emit. req_tready is high only while the sequencer is idle.
// The result sits in an output register, so a new item is accepted while a
// result waits; if rsp_tready stays low, the next result is held back until
// the register is taken. Reset (synchronous, active high) loads the register
// defaults and clears the sequencer, pose, heading, motor angles, last counts
// and pending result. csr_* writes are to be made only while idle; the core
// itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_encoder_odometry_core #(
   parameter int CORDIC_STEPS = 32,
   parameter int COUNT_WIDTH  = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // mode, raw_left, raw_right, zero pad
   input  wire logic [((2*COUNT_WIDTH+8)/8)*8-1:0]    req_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // pos_x, pos_y, heading_out, left_angle, right_angle
   output logic [5*odo_pkg::ACC_W-1:0]                rsp_tdata,
   input  wire logic                                  csr_we,
   input  wire logic [odo_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [odo_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   odo_pkg::cmd_type  cmd;
   odo_pkg::stat_type stat;

   odo_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (req_tdata[0]),
      .stat       (stat),
      .cmd        (cmd)
   );

   odo_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .cnt_left   (req_tdata[COUNT_WIDTH:1]),
      .cnt_right  (req_tdata[2*COUNT_WIDTH:COUNT_WIDTH+1]),
      .mode       (req_tdata[0]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transfer accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the channels");

endmodule
`default_nettype wire

// File: bench/tb_diff_drive_encoder_odometry_core.sv
// Self-checking testbench for the differential-drive odometry core.
`timescale 1ns / 1ps
module tb_diff_drive_encoder_odometry_core;

   localparam int  N_STEPS     = 32;
   localparam int  DRAIN_WAIT  = 400;
   localparam int  HOLD_CYCLES = 3000;
   localparam int  RAND_ITEMS  = 175;   // per random phase, four phases
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int  AW = odo_pkg::ACC_W;
   // indices past the register list
   localparam logic [odo_pkg::CSR_IDX_W-1:0] IDX_SPARE_LO = 3'd5;
   localparam logic [odo_pkg::CSR_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

   typedef struct {
      logic [AW-1:0] px;
      logic [AW-1:0] py;
      logic [AW-1:0] hd;
      logic [AW-1:0] la;
      logic [AW-1:0] ra;
   } pose_type;

   typedef struct {
      int         setting;   // 0 reset defaults, 1 typical, 2 maximum
      logic       mode;
      logic [15:0] left;
      logic [15:0] right;
      logic       zero_known;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [39:0] req_tdata = '0;
   logic req_known = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [5*AW-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [odo_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [odo_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies
   longint enc_range, wrap_thr, dist_cnt, inv_base, ang_cnt;
   // odometry state copy
   longint last_l, last_r, odo_x, odo_y, odo_hd, tot_l, tot_r;

   pose_type pose_q[$];
   int     errors = 0;
   int     results_seen = 0;
   longint cycles = 0;
   bit     quiet = 0;

   diff_drive_encoder_odometry_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic longint sext48(longint v);
      logic signed [AW-1:0] t;
      t = v[AW-1:0];
      return longint'(t);
   endfunction

   // floor(a * b / 2^s), computed with a split at bit 24
   function automatic longint scaled_product(longint a, longint b, int s);
      longint unsigned al;
      longint hi, lo;
      al = longint'(a) & 64'hFF_FFFF;
      hi = a >>> 24;
      lo = longint'(al * longint'(b)) >>> 24;
      return (hi * b + lo) >>> (s - 24);
   endfunction

   function automatic longint atan_q32(int i);
      if (i < 11) return longint'(odo_pkg::ATAN_LOW[i]);
      if (i <= 32) return longint'(1) << (32 - i);
      return 0;
   endfunction

   task automatic heading_trig(input longint ang, output longint c, output longint s);
      longint r, x, y, z, xs, ys, tp, pi, hp;
      bit flip;
      tp = longint'(odo_pkg::TWO_PI_Q32);
      pi = longint'(odo_pkg::PI_Q32);
      hp = longint'(odo_pkg::HALF_PI_Q32);
      r = ang - (ang / tp) * tp;
      flip = 0;
      if (r > pi) r -= tp;
      if (r < -pi) r += tp;
      if (r > hp) begin
         r -= pi; flip = 1;
      end else if (r < -hp) begin
         r += pi; flip = 1;
      end
      x = longint'(odo_pkg::GAIN_Q32);
      y = 0;
      z = r;
      for (int i = 0; i < N_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys; y += xs; z -= atan_q32(i);
         end else begin
            x += ys; y -= xs; z += atan_q32(i);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint count_delta(longint now, longint prev);
      longint d;
      d = now - prev;
      if (d > wrap_thr) d -= enc_range;
      else if (d < -wrap_thr) d += enc_range;
      return d;
   endfunction

   task automatic advance_odometry(input logic mode, input longint rl, input longint rr,
                                   output pose_type p);
      longint dl, dr, ld, rd, mean, dth, c, s;
      if (mode) begin
         odo_x = 0; odo_y = 0; odo_hd = 0; tot_l = 0; tot_r = 0;
      end else begin
         dl = count_delta(rl, last_l);
         dr = count_delta(rr, last_r);
         ld = dl * dist_cnt;
         rd = dr * dist_cnt;
         mean = (ld + rd) >>> 1;
         dth = scaled_product(rd - ld, inv_base, 24);
         odo_hd = sext48(odo_hd + dth);
         heading_trig(odo_hd, c, s);
         odo_x = sext48(odo_x + scaled_product(mean, c, 40));
         odo_y = sext48(odo_y + scaled_product(mean, s, 40));
         tot_l = sext48(tot_l + ((dl * ang_cnt) >>> 8));
         tot_r = sext48(tot_r + ((dr * ang_cnt) >>> 8));
      end
      last_l = rl;
      last_r = rr;
      p.px = odo_x[AW-1:0];
      p.py = odo_y[AW-1:0];
      p.hd = odo_hd[AW-1:0];
      p.la = tot_l[AW-1:0];
      p.ra = tot_r[AW-1:0];
   endtask

   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 200);
   endfunction

   task automatic check_field(string name, logic [AW-1:0] exp_v, logic [AW-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endtask

   // predictor and scoreboard
   always @(posedge clock) begin
      pose_type p, e;
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_odometry(req_tdata[0], longint'(req_tdata[16:1]),
                             longint'(req_tdata[32:17]), p);
            if (req_known) p = '{default: '0};
            pose_q.push_back(p);
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pose_q.size() == 0) begin
               errors++;
               $display("%0t: result transfer with nothing expected: actual %h",
                        $time, rsp_tdata);
            end else begin
               e = pose_q.pop_front();
               check_field("pos_x", e.px, rsp_tdata[0*AW +: AW]);
               check_field("pos_y", e.py, rsp_tdata[1*AW +: AW]);
               check_field("heading", e.hd, rsp_tdata[2*AW +: AW]);
               check_field("left_angle", e.la, rsp_tdata[3*AW +: AW]);
               check_field("right_angle", e.ra, rsp_tdata[4*AW +: AW]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off so the core backs up
   initial begin
      int g;
      bit held;
      held = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_seen >= 60) begin
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (g) @(posedge clock);
            end
         end
      end
   end

   task automatic send_item(logic mode, logic [15:0] l, logic [15:0] r, logic known);
      int g;
      req_tdata  <= {7'b0, r, l, mode};
      req_known  <= known;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pose_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(logic [odo_pkg::CSR_IDX_W-1:0] idx, longint value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[31:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         odo_pkg::REG_ENCODER_RANGE:   enc_range = value & 64'h1_FFFF;
         odo_pkg::REG_WRAP_THRESHOLD:  wrap_thr  = value & 64'hFFFF;
         odo_pkg::REG_DIST_PER_COUNT:  dist_cnt  = value & 64'hFFFF_FFFF;
         odo_pkg::REG_INV_WHEEL_BASE:  inv_base  = value & 64'hFF_FFFF;
         odo_pkg::REG_ANGLE_PER_COUNT: ang_cnt   = value & 64'hFFFF_FFFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_setting(longint rng, longint thr, longint dpc, longint iwb,
                                longint apc);
      csr_write(odo_pkg::REG_ENCODER_RANGE, rng);
      csr_write(odo_pkg::REG_WRAP_THRESHOLD, thr);
      csr_write(odo_pkg::REG_DIST_PER_COUNT, dpc);
      csr_write(odo_pkg::REG_INV_WHEEL_BASE, iwb);
      csr_write(odo_pkg::REG_ANGLE_PER_COUNT, apc);
   endtask

   task automatic random_phase(int n);
      int k;
      logic [15:0] l, r, pl, pr;
      pl = last_l[15:0];
      pr = last_r[15:0];
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 5) begin
            l = $urandom; r = $urandom;
            send_item(1'b1, l, r, 1'b0);
         end else begin
            if (k < 75) begin
               // ordinary motion: small deltas around the previous counts
               l = pl + 16'($signed($urandom_range(0, 400)) - 200);
               r = pr + 16'($signed($urandom_range(0, 400)) - 200);
            end else if (k < 90) begin
               l = pl + 16'($urandom_range(30000, 35000));
               r = pr - 16'($urandom_range(30000, 35000));
            end else begin
               l = $urandom; r = $urandom;
            end
            send_item(1'b0, l, r, 1'b0);
         end
         pl = l;
         pr = r;
      end
   endtask

   stim_row_type rows[] = '{
      '{0, 1'b1, 16'd0,     16'd0,     1'b1},
      '{0, 1'b0, 16'd65535, 16'd0,     1'b1},
      '{0, 1'b0, 16'd0,     16'd65535, 1'b1},
      '{0, 1'b0, 16'd32768, 16'd32767, 1'b1},
      '{0, 1'b1, 16'd65535, 16'd65535, 1'b1},
      '{0, 1'b0, 16'd0,     16'd0,     1'b1},
      '{1, 1'b1, 16'd100,   16'd200,   1'b0},
      '{1, 1'b0, 16'd110,   16'd190,   1'b0},
      '{1, 1'b0, 16'd65535, 16'd0,     1'b0},
      '{1, 1'b0, 16'd0,     16'd65535, 1'b0},
      '{1, 1'b0, 16'd1,     16'd1,     1'b0},
      '{1, 1'b0, 16'd32768, 16'd32768, 1'b0},
      '{1, 1'b0, 16'd65535, 16'd65535, 1'b0},
      '{1, 1'b1, 16'hAAAA,  16'h5555,  1'b0},
      '{1, 1'b0, 16'h5555,  16'hAAAA,  1'b0},
      '{1, 1'b0, 16'd0,     16'd0,     1'b0},
      '{2, 1'b0, 16'd65535, 16'd0,     1'b0},
      '{2, 1'b0, 16'd0,     16'd65535, 1'b0},
      '{2, 1'b0, 16'd32767, 16'd32768, 1'b0},
      '{2, 1'b0, 16'd0,     16'd65535, 1'b0},
      '{2, 1'b0, 16'd32768, 16'd0,     1'b0},
      '{2, 1'b0, 16'd65535, 16'd32768, 1'b0}
   };

   initial begin
      int cur;
      enc_range = 65536; wrap_thr = 32767; dist_cnt = 0; inv_base = 0; ang_cnt = 0;
      last_l = 0; last_r = 0;
      odo_x = 0; odo_y = 0; odo_hd = 0; tot_l = 0; tot_r = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur = 0;
      foreach (rows[i]) begin
         if (rows[i].setting != cur) begin
            drain();
            cur = rows[i].setting;
            if (cur == 1) begin
               write_setting(65536, 32767, 64'd4_000_000, 64'd3_000_000, 64'd900_000_000);
               // indices past the register list must leave everything unchanged
               csr_write(IDX_SPARE_LO, 64'hDEAD_BEEF);
               csr_write(IDX_SPARE_HI, 64'h1234_5678);
            end else begin
               write_setting(65536, 65535, 64'hFFFF_FFFF, 64'hFF_FFFF, 64'hFFFF_FFFF);
            end
         end
         send_item(rows[i].mode, rows[i].left, rows[i].right, rows[i].zero_known);
      end

      drain();
      write_setting(65536, 32767, $urandom, $urandom_range(0, 24'hFF_FFFF), $urandom);
      random_phase(RAND_ITEMS);

      drain();
      quiet = 1;   // a stretch without any idling on either side
      write_setting(1, 0, $urandom_range(0, 5000), $urandom_range(0, 1000), $urandom);
      random_phase(RAND_ITEMS);
      quiet = 0;

      drain();
      // zero modulus: wrap correction adds nothing
      write_setting(0, $urandom_range(0, 65535), $urandom, $urandom_range(0, 24'hFF_FFFF),
                    $urandom);
      random_phase(RAND_ITEMS);

      drain();
      write_setting(40001, 20000, 64'hFFFF_FFFF, 64'hFF_FFFF, 64'hFFFF_FFFF);
      random_phase(RAND_ITEMS);

      drain();
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: diff_drive_encoder_odometry_core.f
rtl/core/odo_pkg.sv
rtl/core/odo_mul.sv
rtl/core/odo_datapath.sv
rtl/core/odo_ctrl.sv
rtl/core/diff_drive_encoder_odometry_core.sv
bench/tb_diff_drive_encoder_odometry_core.sv
